### rtl/apsphc_pkg.sv
// Shared constants and the controller and datapath types for the shortest path hop check.
`default_nettype none

package apsphc_pkg;

    // Default sizes of the node tables and of an edge weight.
    localparam int MAX_NODES_DEF   = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed field widths of the item streams and the node count register.
    localparam int NODE_BITS  = 4;
    localparam int CFG_BITS   = 5;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_BITS-1:0] NODE_COUNT_RST = 5'd16;

    // Action code of an input item; the other code adds an edge.
    localparam logic ACTION_RUN = 1'b1;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_EDGE_RD,
        OP_EDGE_WR,
        OP_RUN_START,
        OP_IK_RD,
        OP_IK_LATCH,
        OP_J_RD,
        OP_J_SUM,
        OP_J_WR,
        OP_CHK_RD,
        OP_CHK_EVAL,
        OP_EMIT,
        OP_CLR_WR
    } t_dp_op;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        logic ik_reach;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/apsphc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module apsphc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/apsphc_dp.sv
// Datapath: pair tables in two mirrored RAMs, relaxation arithmetic, verdict and output register.
`default_nettype none

module apsphc_dp
    import apsphc_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    localparam int IDX_W = $clog2(MAX_NODES)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_op                 i_op,
    input  logic [IDX_W-1:0]       i_k,
    input  logic [IDX_W-1:0]       i_i,
    input  logic [IDX_W-1:0]       i_j,
    input  logic [NODE_BITS-1:0]   i_src,
    input  logic [NODE_BITS-1:0]   i_dst,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic                   i_out_ready,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    output logic                   o_alive
);

    localparam int HOP_W  = IDX_W;
    localparam int DIST_W = WEIGHT_BITS + IDX_W;
    localparam int SUM_W  = DIST_W + 1;
    localparam int HSUM_W = HOP_W + 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    typedef struct packed {
        logic              reach;
        logic [HOP_W-1:0]  hop;
        logic [DIST_W-1:0] red;
        logic [DIST_W-1:0] len;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    t_entry              w_rd_a;
    t_entry              w_rd_b;
    logic [ADDR_W-1:0]   w_rd_addr_a;
    logic [ADDR_W-1:0]   w_rd_addr_b;
    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    t_entry              w_wr_data;
    logic [IDX_W-1:0]    w_src_idx;
    logic [IDX_W-1:0]    w_dst_idx;
    logic                w_edge_ok;
    t_entry              w_edge_entry;
    t_entry              w_relax_entry;
    t_entry              w_clear_entry;
    logic [DIST_W-1:0]   w_w_ext;
    logic [DIST_W-1:0]   w_w_less;
    logic [SUM_W-1:0]    w_chk_lhs;

    logic [IDX_W-1:0]       r_src_idx;
    logic [IDX_W-1:0]       r_dst_idx;
    logic [WEIGHT_BITS-1:0] r_w;
    logic                   r_edge_ok;
    t_entry                 r_ik;
    t_entry                 r_ij;
    logic                   r_kj_reach;
    logic [SUM_W-1:0]       r_sum_d;
    logic [SUM_W-1:0]       r_sum_r;
    logic [HSUM_W-1:0]      r_sum_h;
    logic                   r_ok;
    logic                   r_alive;
    logic                   r_out_valid;

    // Both copies take every write; copy A reads pair (i,j), (i,k) or the edge's pair, copy B reads pair (k,j).
    apsphc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr_a),
        .o_rd_data (w_rd_a)
    );

    apsphc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr_b),
        .o_rd_data (w_rd_b)
    );

    // Edge item decode: out-of-range nodes, zero weights and self loops are dropped.
    assign w_src_idx = IDX_W'(i_src);
    assign w_dst_idx = IDX_W'(i_dst);
    assign w_edge_ok = (32'(i_src) < 32'(MAX_NODES)) && (32'(i_dst) < 32'(MAX_NODES))
                       && (i_weight != '0) && (i_src != i_dst);

    // Read addresses.
    always_comb begin
        case (i_op)
            OP_EDGE_RD: w_rd_addr_a = {w_src_idx, w_dst_idx};
            OP_IK_RD:   w_rd_addr_a = {i_i, i_k};
            default:    w_rd_addr_a = {i_i, i_j};
        endcase
    end

    assign w_rd_addr_b = {i_k, i_j};

    // Edge merge: keep the smaller weight of parallel edges.
    assign w_w_ext  = DIST_W'(r_w);
    assign w_w_less = w_w_ext - DIST_W'(1);

    always_comb begin
        w_edge_entry       = w_rd_a;
        w_edge_entry.reach = 1'b1;
        w_edge_entry.hop   = HOP_W'(1);
        if (!w_rd_a.reach) begin
            w_edge_entry.len = w_w_ext;
            w_edge_entry.red = w_w_less;
        end else begin
            if (w_w_ext < w_rd_a.len) begin
                w_edge_entry.len = w_w_ext;
            end
            if (w_w_less < w_rd_a.red) begin
                w_edge_entry.red = w_w_less;
            end
        end
    end

    // Relaxation of pair (i,j) through node k.
    always_comb begin
        w_relax_entry = r_ij;
        if (!r_ij.reach) begin
            w_relax_entry.reach = 1'b1;
            w_relax_entry.len   = DIST_W'(r_sum_d);
            w_relax_entry.red   = DIST_W'(r_sum_r);
            w_relax_entry.hop   = HOP_W'(r_sum_h);
        end else begin
            if (SUM_W'(r_ij.len) > r_sum_d) begin
                w_relax_entry.len = DIST_W'(r_sum_d);
                w_relax_entry.hop = HOP_W'(r_sum_h);
            end else if ((SUM_W'(r_ij.len) == r_sum_d) && (r_sum_h > HSUM_W'(r_ij.hop))) begin
                w_relax_entry.hop = HOP_W'(r_sum_h);
            end
            if (r_sum_r < SUM_W'(r_ij.red)) begin
                w_relax_entry.red = DIST_W'(r_sum_r);
            end
        end
    end

    // Cleared entry: only the diagonal is reachable, at distance zero.
    always_comb begin
        w_clear_entry       = '0;
        w_clear_entry.reach = (i_i == i_j);
    end

    // Write port selection.
    always_comb begin
        case (i_op)
            OP_EDGE_WR: begin
                w_wr_en   = r_edge_ok;
                w_wr_addr = {r_src_idx, r_dst_idx};
                w_wr_data = w_edge_entry;
            end
            OP_J_WR: begin
                w_wr_en   = r_kj_reach;
                w_wr_addr = {i_i, i_j};
                w_wr_data = w_relax_entry;
            end
            OP_CLR_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = {i_i, i_j};
                w_wr_data = w_clear_entry;
            end
            default: begin
                w_wr_en   = 1'b0;
                w_wr_addr = {i_i, i_j};
                w_wr_data = w_clear_entry;
            end
        endcase
    end

    // A reachable pair passes when reduced plus hops gives the distance.
    assign w_chk_lhs = SUM_W'(w_rd_a.red) + SUM_W'(w_rd_a.hop);

    // Working registers of the current operation.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_EDGE_RD: begin
                r_src_idx <= w_src_idx;
                r_dst_idx <= w_dst_idx;
                r_w       <= i_weight;
                r_edge_ok <= w_edge_ok;
            end
            OP_RUN_START: begin
                r_ok <= 1'b1;
            end
            OP_IK_LATCH: begin
                r_ik <= w_rd_a;
            end
            OP_J_SUM: begin
                r_ij       <= w_rd_a;
                r_kj_reach <= w_rd_b.reach;
                r_sum_d    <= SUM_W'(r_ik.len) + SUM_W'(w_rd_b.len);
                r_sum_r    <= SUM_W'(r_ik.red) + SUM_W'(w_rd_b.red);
                r_sum_h    <= HSUM_W'(r_ik.hop) + HSUM_W'(w_rd_b.hop);
            end
            OP_CHK_EVAL: begin
                if (w_rd_a.reach && (w_chk_lhs != SUM_W'(w_rd_a.len))) begin
                    r_ok <= 1'b0;
                end
            end
            OP_EMIT: begin
                r_alive <= r_ok;
            end
            default: begin
                r_ok <= r_ok;
            end
        endcase
    end

    // Output item register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.ik_reach = w_rd_a.reach;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_alive           = r_alive;

endmodule

`default_nettype wire

### rtl/apsphc_ctrl.sv
// Controller: item acceptance, node count register and the loop sequencer over k, i and j.
`default_nettype none

module apsphc_ctrl
    import apsphc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int IDX_W = $clog2(MAX_NODES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_BITS-1:0] i_cfg_wr_data,
    input  logic                i_in_valid,
    input  logic                i_in_action,
    output logic                o_in_ready,
    input  t_dp_status          i_status,
    output t_dp_op              o_op,
    output logic [IDX_W-1:0]    o_k,
    output logic [IDX_W-1:0]    o_i,
    output logic [IDX_W-1:0]    o_j
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_EDGE_WR  = 11'b000_0000_0010,
        ST_IK_RD    = 11'b000_0000_0100,
        ST_IK_LATCH = 11'b000_0000_1000,
        ST_J_RD     = 11'b000_0001_0000,
        ST_J_SUM    = 11'b000_0010_0000,
        ST_J_WR     = 11'b000_0100_0000,
        ST_CHK_RD   = 11'b000_1000_0000,
        ST_CHK_EVAL = 11'b001_0000_0000,
        ST_EMIT     = 11'b010_0000_0000,
        ST_CLEAR    = 11'b100_0000_0000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [IDX_W-1:0]    r_k;
    logic [IDX_W-1:0]    n_k;
    logic [IDX_W-1:0]    r_i;
    logic [IDX_W-1:0]    n_i;
    logic [IDX_W-1:0]    r_j;
    logic [IDX_W-1:0]    n_j;
    logic [IDX_W-1:0]    r_n_last;
    logic [IDX_W-1:0]    n_n_last;
    logic [CFG_BITS-1:0] r_node_count;

    logic [IDX_W-1:0] w_n_last;
    logic             w_last_k;
    logic             w_last_i;
    logic             w_last_j;
    t_state           w_row_state;
    logic [IDX_W-1:0] w_row_k;
    logic [IDX_W-1:0] w_row_i;

    // Node count clamped to the table size; zero acts as one node.
    always_comb begin
        if (r_node_count == '0) begin
            w_n_last = '0;
        end else if (32'(r_node_count) > 32'(MAX_NODES)) begin
            w_n_last = IDX_W'(MAX_NODES - 1);
        end else begin
            w_n_last = IDX_W'(r_node_count - CFG_BITS'(1));
        end
    end

    assign w_last_k = (r_k == r_n_last);
    assign w_last_i = (r_i == r_n_last);
    assign w_last_j = (r_j == r_n_last);

    // Step to the next (k, i) row, or on to the verdict scan after the last one.
    always_comb begin
        w_row_k = r_k;
        w_row_i = r_i + IDX_W'(1);
        w_row_state = ST_IK_RD;
        if (w_last_i) begin
            w_row_i = '0;
            if (w_last_k) begin
                w_row_state = ST_CHK_RD;
            end else begin
                w_row_k = r_k + IDX_W'(1);
            end
        end
    end

    // Next state and datapath operation.
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_i      = r_i;
        n_j      = r_j;
        n_n_last = r_n_last;
        o_op     = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_action == ACTION_RUN) begin
                        o_op     = OP_RUN_START;
                        n_n_last = w_n_last;
                        n_k      = '0;
                        n_i      = '0;
                        n_state  = ST_IK_RD;
                    end else begin
                        o_op    = OP_EDGE_RD;
                        n_state = ST_EDGE_WR;
                    end
                end
            end
            ST_EDGE_WR: begin
                o_op    = OP_EDGE_WR;
                n_state = ST_IDLE;
            end
            ST_IK_RD: begin
                o_op    = OP_IK_RD;
                n_state = ST_IK_LATCH;
            end
            ST_IK_LATCH: begin
                o_op = OP_IK_LATCH;
                if (i_status.ik_reach) begin
                    n_j     = '0;
                    n_state = ST_J_RD;
                end else begin
                    n_k     = w_row_k;
                    n_i     = w_row_i;
                    n_j     = '0;
                    n_state = w_row_state;
                end
            end
            ST_J_RD: begin
                o_op    = OP_J_RD;
                n_state = ST_J_SUM;
            end
            ST_J_SUM: begin
                o_op    = OP_J_SUM;
                n_state = ST_J_WR;
            end
            ST_J_WR: begin
                o_op = OP_J_WR;
                if (w_last_j) begin
                    n_k     = w_row_k;
                    n_i     = w_row_i;
                    n_j     = '0;
                    n_state = w_row_state;
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = ST_J_RD;
                end
            end
            ST_CHK_RD: begin
                o_op    = OP_CHK_RD;
                n_state = ST_CHK_EVAL;
            end
            ST_CHK_EVAL: begin
                o_op = OP_CHK_EVAL;
                if (w_last_j) begin
                    n_j = '0;
                    if (w_last_i) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_i     = r_i + IDX_W'(1);
                        n_state = ST_CHK_RD;
                    end
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = ST_CHK_RD;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_op    = OP_EMIT;
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                o_op = OP_CLR_WR;
                n_j  = r_j + IDX_W'(1);
                if (&r_j) begin
                    n_i = r_i + IDX_W'(1);
                    if (&r_i) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, loop counters and node count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_k          <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_n_last     <= '0;
            r_node_count <= NODE_COUNT_RST;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_i      <= n_i;
            r_j      <= n_j;
            r_n_last <= n_n_last;
            if (i_cfg_wr_en) begin
                r_node_count <= i_cfg_wr_data;
            end
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_k        = r_k;
    assign o_i        = r_i;
    assign o_j        = r_j;

endmodule

`default_nettype wire

### rtl/all_pairs_shortest_path_hop_check_core.sv
// Top level of the all-pairs shortest path hop check.
`default_nettype none

// Edge items (tuser low) are merged into the pair tables, keeping the smaller weight of
// parallel edges. A run item (tuser high) performs Floyd-Warshall over the first n nodes,
// n being the node count register clamped to 1..MAX_NODES, then scans every pair of those
// nodes and delivers one verdict item: alive is 1 when every reachable pair has a
// reduced distance (all weights minus one) equal to its distance minus its largest hop
// count. A run ends by clearing every cell of the tables; the same clearing pass runs
// after reset. The pair tables sit in two mirrored single-port-read RAMs, and each
// relaxation step reads, sums, then compares and writes. No item is accepted during a
// run or a clearing pass; the verdict waits in an output register, and the next run
// stalls before its own verdict until the previous one has been taken.
module all_pairs_shortest_path_hop_check_core
    import apsphc_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_BITS-1:0]   i_cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // src, dst, weight from bit 0 up, zero filled to whole bytes
    input  logic [((2*NODE_BITS+WEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // alive in bit 0, zero filled
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(MAX_NODES);

    t_dp_op                 w_op;
    t_dp_status             w_status;
    logic [IDX_W-1:0]       w_k;
    logic [IDX_W-1:0]       w_i;
    logic [IDX_W-1:0]       w_j;
    logic [NODE_BITS-1:0]   w_src;
    logic [NODE_BITS-1:0]   w_dst;
    logic [WEIGHT_BITS-1:0] w_weight;
    logic                   w_alive;

    // Unpack the input item.
    assign w_src    = s_axis_tdata[NODE_BITS-1:0];
    assign w_dst    = s_axis_tdata[2*NODE_BITS-1:NODE_BITS];
    assign w_weight = s_axis_tdata[2*NODE_BITS+WEIGHT_BITS-1:2*NODE_BITS];

    apsphc_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_action   (s_axis_tuser),
        .o_in_ready    (s_axis_tready),
        .i_status      (w_status),
        .o_op          (w_op),
        .o_k           (w_k),
        .o_i           (w_i),
        .o_j           (w_j)
    );

    apsphc_dp #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_k         (w_k),
        .i_i         (w_i),
        .i_j         (w_j),
        .i_src       (w_src),
        .i_dst       (w_dst),
        .i_weight    (w_weight),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_alive     (w_alive)
    );

    // Pack the verdict item.
    assign m_axis_tdata = {(OUT_DATA_W-1)'(0), w_alive};

endmodule

`default_nettype wire

### dv/all_pairs_shortest_path_hop_check_core_tb.sv
// Self-checking testbench for the all-pairs shortest path hop check core.
`timescale 1ns / 100ps

module all_pairs_shortest_path_hop_check_core_tb;
    import apsphc_pkg::*;

    localparam int IN_DATA_W   = ((2*NODE_BITS+WEIGHT_BITS_DEF+7)/8)*8;
    localparam int CELLS       = MAX_NODES_DEF*MAX_NODES_DEF;
    localparam int STALL_LIMIT = 60000;
    localparam int SETTLE_CYC  = 300;
    localparam int RANDOM_CMDS = 850;
    localparam int MIN_RUNS    = 60;
    localparam logic ACTION_EDGE = ~ACTION_RUN;

    // One item toward the block: an edge load or a run request.
    typedef struct packed {
        logic                       action;
        logic [NODE_BITS-1:0]       src;
        logic [NODE_BITS-1:0]       dst;
        logic [WEIGHT_BITS_DEF-1:0] weight;
    } t_graph_cmd;

    // Readiness patterns of the verdict receiver.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE
    } t_rx_mood;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]    i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // src, dst, weight from bit 0 up
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    // action
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // alive in bit 0, zero filled
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    // Pending items and verdicts still owed by the block.
    t_graph_cmd cmds_to_send[$];
    logic       verdicts_due[$];

    // Mirror of the pair tables and the node count register.
    longint unsigned     path_len [CELLS];
    longint unsigned     trimmed_len [CELLS];
    int unsigned         hop_cnt [CELLS];
    bit                  reach [CELLS];
    logic [CFG_BITS-1:0] node_count_cfg = NODE_COUNT_RST;

    int err_count = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int cmds_queued = 0;
    int runs_queued = 0;
    t_rx_mood rx_mood = RX_OPEN;
    int mood_left = 0;

    all_pairs_shortest_path_hop_check_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Every pair unreachable except the diagonal, which sits at distance zero.
    function automatic void wipe_tables();
        for (int c = 0; c < CELLS; c++) begin
            path_len[c]    = 0;
            trimmed_len[c] = 0;
            hop_cnt[c]     = 0;
            reach[c]       = (c / MAX_NODES_DEF) == (c % MAX_NODES_DEF);
        end
    endfunction

    // Merge one edge, keeping the lighter of parallel edges.
    function automatic void merge_edge(input logic [NODE_BITS-1:0] src,
                                       input logic [NODE_BITS-1:0] dst,
                                       input logic [WEIGHT_BITS_DEF-1:0] weight);
        int idx;
        longint unsigned w;
        w = 64'(weight);
        if (w == 0 || src == dst) begin
            return;
        end
        idx = src*MAX_NODES_DEF + dst;
        if (!reach[idx]) begin
            reach[idx]       = 1'b1;
            path_len[idx]    = w;
            trimmed_len[idx] = w - 1;
        end else begin
            if (w < path_len[idx]) begin
                path_len[idx] = w;
            end
            if (w - 1 < trimmed_len[idx]) begin
                trimmed_len[idx] = w - 1;
            end
        end
        hop_cnt[idx] = 1;
    endfunction

    // Relax all pairs over the active nodes and judge the hop relation.
    function automatic logic relax_and_judge();
        int n, ik, kj, ij;
        longint unsigned s, r;
        int unsigned h;
        logic alive;
        alive = 1'b1;
        n = int'(node_count_cfg);
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_NODES_DEF) begin
            n = MAX_NODES_DEF;
        end
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < n; i++) begin
                ik = i*MAX_NODES_DEF + k;
                if (!reach[ik]) begin
                    continue;
                end
                for (int j = 0; j < n; j++) begin
                    kj = k*MAX_NODES_DEF + j;
                    ij = i*MAX_NODES_DEF + j;
                    if (!reach[kj]) begin
                        continue;
                    end
                    s = path_len[ik] + path_len[kj];
                    r = trimmed_len[ik] + trimmed_len[kj];
                    h = hop_cnt[ik] + hop_cnt[kj];
                    if (!reach[ij]) begin
                        reach[ij]       = 1'b1;
                        path_len[ij]    = s;
                        trimmed_len[ij] = r;
                        hop_cnt[ij]     = h;
                        continue;
                    end
                    if (path_len[ij] > s) begin
                        path_len[ij] = s;
                        hop_cnt[ij]  = h;
                    end else if (path_len[ij] == s && h > hop_cnt[ij]) begin
                        hop_cnt[ij] = h;
                    end
                    if (r < trimmed_len[ij]) begin
                        trimmed_len[ij] = r;
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                ij = i*MAX_NODES_DEF + j;
                if (reach[ij] && trimmed_len[ij] + hop_cnt[ij] != path_len[ij]) begin
                    alive = 1'b0;
                end
            end
        end
        return alive;
    endfunction

    // Fold an accepted item into the mirror; a run owes one verdict.
    function automatic void absorb_cmd(input t_graph_cmd cmd);
        if (cmd.action == ACTION_RUN) begin
            verdicts_due = {verdicts_due, relax_and_judge()};
            wipe_tables();
        end else begin
            merge_edge(cmd.src, cmd.dst, cmd.weight);
        end
    endfunction

    function automatic void note_mismatch(input string what, input logic want,
                                          input logic got);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t: %s: expected alive=%b, got alive=%b", $realtime, what, want, got);
        end
    endfunction

    // Item driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : drive_cmds
        bit fired;
        fired = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (fired) begin
                absorb_cmd(cmds_to_send.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        8:          gap_left = $urandom_range(5, 12);
                        9:          gap_left = $urandom_range(20, 40);
                        default:    gap_left = $urandom_range(1, 4);
                    endcase
                end
            end
            if (!s_axis_tvalid || fired) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmds_to_send.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({cmds_to_send[0].weight,
                                                 cmds_to_send[0].dst,
                                                 cmds_to_send[0].src});
                    s_axis_tuser  <= cmds_to_send[0].action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Verdict monitor with its own stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    note_mismatch("verdict with none pending", 1'bx, m_axis_tdata[0]);
                end else if (m_axis_tdata[0] !== verdicts_due[0]) begin
                    note_mismatch("verdict mismatch", verdicts_due.pop_front(),
                                  m_axis_tdata[0]);
                end else begin
                    void'(verdicts_due.pop_front());
                end
            end
            if (mood_left == 0) begin
                mood_left = $urandom_range(30, 150);
                rx_mood   = t_rx_mood'($urandom_range(0, 2));
            end else begin
                mood_left--;
            end
            case (rx_mood)
                RX_OPEN:  m_axis_tready <= 1'b1;
                RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
                default:  m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog on cycles without any accepted item on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_cmd(input logic action, input logic [NODE_BITS-1:0] src,
                             input logic [NODE_BITS-1:0] dst,
                             input logic [WEIGHT_BITS_DEF-1:0] weight);
        t_graph_cmd cmd;
        cmd.action = action;
        cmd.src    = src;
        cmd.dst    = dst;
        cmd.weight = weight;
        cmds_to_send = {cmds_to_send, cmd};
    endtask

    // Wait until every item is in and every verdict is out, then let the clear pass end.
    task automatic drain();
        @(negedge i_clk);
        while (cmds_to_send.size() != 0 || verdicts_due.size() != 0 || s_axis_tvalid) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [CFG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b1;
        i_cfg_wr_data  <= value;
        node_count_cfg = value;
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b0;
    endtask

    function automatic logic [WEIGHT_BITS_DEF-1:0] pick_weight(input int style);
        case (style)
            0:       return WEIGHT_BITS_DEF'($urandom_range(1, 3));
            1:       return WEIGHT_BITS_DEF'($urandom_range(1, 12));
            2:       return WEIGHT_BITS_DEF'($urandom_range(1, 65535));
            default: return WEIGHT_BITS_DEF'(($urandom_range(0, 4) == 0)
                                             ? $urandom_range(60000, 65535)
                                             : $urandom_range(1, 40));
        endcase
    endfunction

    // Random graph over the active nodes with some stray edges, closed by a run.
    task automatic build_graph(input int n_eff);
        int n_edges, style;
        logic [NODE_BITS-1:0] s, d;
        logic [WEIGHT_BITS_DEF-1:0] w;
        style   = $urandom_range(0, 3);
        n_edges = $urandom_range(0, 3*n_eff);
        for (int e = 0; e < n_edges; e++) begin
            if ($urandom_range(0, 9) == 0) begin
                s = NODE_BITS'($urandom);
                d = NODE_BITS'($urandom);
                w = ($urandom_range(0, 3) == 0) ? '0 : WEIGHT_BITS_DEF'($urandom);
            end else begin
                s = NODE_BITS'($urandom_range(0, n_eff-1));
                d = NODE_BITS'($urandom_range(0, n_eff-1));
                w = pick_weight(style);
            end
            queue_cmd(ACTION_EDGE, s, d, w);
        end
        queue_cmd(ACTION_RUN, NODE_BITS'($urandom), NODE_BITS'($urandom),
                  WEIGHT_BITS_DEF'($urandom));
        cmds_queued += n_edges + 1;
        runs_queued++;
    endtask

    initial begin
        int pick, n_eff, graphs;
        logic [CFG_BITS-1:0] nc;
        wipe_tables();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset node count: extreme indices, a dropped zero weight, a self loop
        // and a lighter parallel edge give a live graph.
        @(negedge i_clk);
        queue_cmd(ACTION_EDGE, 4'd0, 4'd15, 16'hFFFF);
        queue_cmd(ACTION_EDGE, 4'd15, 4'd0, 16'd1);
        queue_cmd(ACTION_EDGE, 4'd0, 4'd15, 16'd0);
        queue_cmd(ACTION_EDGE, 4'd3, 4'd3, 16'd7);
        queue_cmd(ACTION_EDGE, 4'd0, 4'd15, 16'hFFFE);
        queue_cmd(ACTION_RUN, 4'd15, 4'd15, 16'hFFFF);
        // A three-hop detour of weight three beside a direct edge of two: dead.
        queue_cmd(ACTION_EDGE, 4'd4, 4'd5, 16'd1);
        queue_cmd(ACTION_EDGE, 4'd5, 4'd6, 16'd1);
        queue_cmd(ACTION_EDGE, 4'd6, 4'd7, 16'd1);
        queue_cmd(ACTION_EDGE, 4'd4, 4'd7, 16'd2);
        queue_cmd(ACTION_RUN, 4'd0, 4'd0, 16'd0);
        drain();

        // A zero node count acts as one node.
        write_node_count(5'd0);
        @(negedge i_clk);
        queue_cmd(ACTION_EDGE, 4'd0, 4'd1, 16'd9);
        queue_cmd(ACTION_RUN, 4'd0, 4'd0, 16'd0);
        drain();

        // The same dead detour through nodes outside the active two is not seen.
        write_node_count(5'd2);
        @(negedge i_clk);
        queue_cmd(ACTION_EDGE, 4'd0, 4'd1, 16'd2);
        queue_cmd(ACTION_EDGE, 4'd0, 4'd5, 16'd1);
        queue_cmd(ACTION_EDGE, 4'd5, 4'd6, 16'd1);
        queue_cmd(ACTION_EDGE, 4'd6, 4'd1, 16'd1);
        queue_cmd(ACTION_RUN, 4'd0, 4'd0, 16'd0);
        drain();

        // Oversized node count on an empty table.
        write_node_count(5'd31);
        @(negedge i_clk);
        queue_cmd(ACTION_RUN, 4'd0, 4'd0, 16'd0);
        drain();

        // Random phases, most of them on small graphs.
        while (cmds_queued < RANDOM_CMDS || runs_queued < MIN_RUNS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                nc = CFG_BITS'($urandom_range(2, 6));
            end else if (pick < 80) begin
                nc = CFG_BITS'($urandom_range(7, 11));
            end else if (pick < 85) begin
                nc = 5'd16;
            end else if (pick < 90) begin
                nc = 5'd1;
            end else if (pick < 93) begin
                nc = 5'd0;
            end else begin
                nc = CFG_BITS'($urandom_range(17, 31));
            end
            n_eff  = (nc == 0) ? 1 : (nc > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(nc);
            graphs = (n_eff > 11) ? 1 : $urandom_range(1, 4);
            write_node_count(nc);
            @(negedge i_clk);
            repeat (graphs) build_graph(n_eff);
            drain();
        end

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
